### sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the read request coalescer.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RRC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define RRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### sv/rrc_pkg.sv
// ---------------------------------------------------------------------------
// rrc_pkg
// Types and constants of the read request coalescer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rrc_pkg;

  localparam int SPEED_W = 17;
  localparam int LIMIT_W = 13;
  localparam int LIM_W   = 22;
  localparam int CSIZE_W = 7;

  localparam logic [SPEED_W-1:0] DEFAULT_KHZ   = 17'd4000;
  localparam logic [LIMIT_W-1:0] GAP_MIN       = 13'd64;
  localparam logic [LIMIT_W-1:0] RUN_MIN       = 13'd256;
  localparam logic [LIMIT_W-1:0] LIMIT_MAX     = 13'd4096;
  localparam logic [CSIZE_W-1:0] SIZE_MAX_LEAF = 7'd64;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = 2;
  localparam int CNT_W      = 3;

  typedef struct packed {
    logic [31:0] leaf_addr;
    logic [15:0] leaf_size;
    logic        leaf_watched;
    logic        last_leaf;
  } leaf_t;

  typedef struct packed {
    logic [31:0] read_addr;
    logic [12:0] run_len;
    logic [9:0]  first_pos;
    logic [10:0] run_count;
    logic        final_run;
  } run_t;

endpackage

### sv/rrc_leaf_if.sv
// ---------------------------------------------------------------------------
// rrc_leaf_if
// Valid/ready channel that carries one watched-variable descriptor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rrc_leaf_if;
  import rrc_pkg::*;

  logic  valid;
  logic  ready;
  leaf_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### sv/rrc_run_if.sv
// ---------------------------------------------------------------------------
// rrc_run_if
// Valid/ready channel that carries one block-read request.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rrc_run_if;
  import rrc_pkg::*;

  logic valid;
  logic ready;
  run_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### sv/read_request_coalescer_core.sv
// ---------------------------------------------------------------------------
// read_request_coalescer_core
// Merges address-sorted variable descriptors into block-read requests.
// ---------------------------------------------------------------------------
// A request is written into the registered request queue on the leaf transfer and is offered on out_ch from there.
// Throughput: one leaf per cycle while out_ch takes each request and each leaf
// yields at most one request; a leaf that splits a run and also closes the list yields two requests.
// The four-entry request queue sets the rate: in_ch.ready needs two free slots.
// Reset (synchronous, rst_n low) closes any run, clears the queue and the
// position count, and sets both limits to LIMIT_MAX, the values that 4000 kHz selects.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module read_request_coalescer_core #(
  parameter int MAX_LEAVES = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [rrc_pkg::SPEED_W-1:0]   cfg_wdata,
  rrc_leaf_if.sink                      in_ch,
  rrc_run_if.source                     out_ch
);
  import rrc_pkg::*;

  localparam int POS_W  = $clog2(MAX_LEAVES + 1);
  localparam int CALC_W = (POS_W > 11) ? POS_W : 11;

  logic [LIMIT_W-1:0] gap_r, run_r;
  logic [LIMIT_W-1:0] gap_nxt, run_nxt;
  logic [SPEED_W-1:0] speed;
  logic [LIM_W-1:0]   lim;

  logic [31:0]        open_start_r, open_start_nxt;
  logic [32:0]        open_end_r, open_end_nxt;
  logic [POS_W-1:0]   open_first_r, open_first_nxt;
  logic [POS_W-1:0]   wp_r, wp_nxt;
  logic               run_open_r, run_open_nxt;

  run_t               mem [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r;

  logic               in_acc, out_acc;
  logic               take, split, emit_final;
  logic [CSIZE_W-1:0] size_c;
  logic [32:0]        leaf_end;
  logic [31:0]        ns_start;
  logic [32:0]        ns_end;
  logic [POS_W-1:0]   ns_first, ns_wp;
  logic               ns_open;
  logic [32:0]        diff;
  run_t               split_res, final_res;
  run_t               e0, e1;
  logic               push0, push1;
  logic [1:0]         push_n;
  logic [32:0]        len_open, len_ns;
  logic [CALC_W-1:0]  cnt_open, cnt_ns;

  // Link speed to limits: 250 / 10 bytes per kHz is an exact multiply by 25.
  always_comb begin
    speed = (cfg_wdata == '0) ? DEFAULT_KHZ : cfg_wdata;
    lim   = (LIM_W'(speed) << 4) + (LIM_W'(speed) << 3) + LIM_W'(speed);
    if (lim < LIM_W'(GAP_MIN)) begin
      gap_nxt = GAP_MIN;
    end else if (lim > LIM_W'(LIMIT_MAX)) begin
      gap_nxt = LIMIT_MAX;
    end else begin
      gap_nxt = lim[LIMIT_W-1:0];
    end
    if (lim < LIM_W'(RUN_MIN)) begin
      run_nxt = RUN_MIN;
    end else if (lim > LIM_W'(LIMIT_MAX)) begin
      run_nxt = LIMIT_MAX;
    end else begin
      run_nxt = lim[LIMIT_W-1:0];
    end
  end

  assign in_ch.ready = (count_r <= CNT_W'(FIFO_DEPTH - 2));
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = (count_r != '0);
  assign out_ch.data  = mem[rd_ptr_r];
  assign out_acc      = out_ch.valid && out_ch.ready;

  always_comb begin
    take = in_ch.data.leaf_watched && (wp_r < POS_W'(MAX_LEAVES));
    if (in_ch.data.leaf_size == '0) begin
      size_c = CSIZE_W'(1);
    end else if (in_ch.data.leaf_size > 16'(SIZE_MAX_LEAF)) begin
      size_c = SIZE_MAX_LEAF;
    end else begin
      size_c = in_ch.data.leaf_size[CSIZE_W-1:0];
    end
    leaf_end = {1'b0, in_ch.data.leaf_addr} + 33'(size_c);
    diff     = leaf_end - {1'b0, open_start_r};
    split = take && run_open_r &&
            (({2'b00, in_ch.data.leaf_addr} > ({1'b0, open_end_r} + 34'(gap_r))) ||
             (leaf_end < {1'b0, open_start_r}) ||
             (diff > 33'(run_r)));

    ns_start = open_start_r;
    ns_end   = open_end_r;
    ns_first = open_first_r;
    ns_wp    = wp_r;
    ns_open  = run_open_r;
    if (take) begin
      ns_wp   = wp_r + POS_W'(1);
      ns_open = 1'b1;
      if (split || !run_open_r) begin
        ns_start = in_ch.data.leaf_addr;
        ns_end   = leaf_end;
        ns_first = wp_r;
      end else if (leaf_end > open_end_r) begin
        ns_end = leaf_end;
      end
    end

    len_open = open_end_r - {1'b0, open_start_r};
    cnt_open = CALC_W'(wp_r) - CALC_W'(open_first_r);
    split_res.read_addr = open_start_r;
    split_res.run_len   = len_open[12:0];
    split_res.first_pos = 10'(CALC_W'(open_first_r));
    split_res.run_count = cnt_open[10:0];
    split_res.final_run = 1'b0;

    len_ns = ns_end - {1'b0, ns_start};
    cnt_ns = CALC_W'(ns_wp) - CALC_W'(ns_first);
    final_res.read_addr = ns_start;
    final_res.run_len   = len_ns[12:0];
    final_res.first_pos = 10'(CALC_W'(ns_first));
    final_res.run_count = cnt_ns[10:0];
    final_res.final_run = 1'b1;

    emit_final = in_ch.data.last_leaf && ns_open;
    e0     = split ? split_res : final_res;
    e1     = final_res;
    push0  = in_acc && (split || emit_final);
    push1  = in_acc && split && emit_final;
    push_n = {1'b0, push0} + {1'b0, push1};

    open_start_nxt = open_start_r;
    open_end_nxt   = open_end_r;
    open_first_nxt = open_first_r;
    wp_nxt         = wp_r;
    run_open_nxt   = run_open_r;
    if (in_acc) begin
      if (in_ch.data.last_leaf) begin
        open_start_nxt = '0;
        open_end_nxt   = '0;
        open_first_nxt = '0;
        wp_nxt         = '0;
        run_open_nxt   = 1'b0;
      end else begin
        open_start_nxt = ns_start;
        open_end_nxt   = ns_end;
        open_first_nxt = ns_first;
        wp_nxt         = ns_wp;
        run_open_nxt   = ns_open;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r        <= LIMIT_MAX;
      run_r        <= LIMIT_MAX;
      open_start_r <= '0;
      open_end_r   <= '0;
      open_first_r <= '0;
      wp_r         <= '0;
      run_open_r   <= 1'b0;
      wr_ptr_r     <= '0;
      rd_ptr_r     <= '0;
      count_r      <= '0;
    end else begin
      if (cfg_we) begin
        gap_r <= gap_nxt;
        run_r <= run_nxt;
      end
      open_start_r <= open_start_nxt;
      open_end_r   <= open_end_nxt;
      open_first_r <= open_first_nxt;
      wp_r         <= wp_nxt;
      run_open_r   <= run_open_nxt;
      wr_ptr_r     <= wr_ptr_r + PTR_W'(push_n);
      if (out_acc) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      count_r <= count_r + CNT_W'(push_n) - CNT_W'(out_acc);
    end
  end

  always_ff @(posedge clk) begin
    if (push0) begin
      mem[wr_ptr_r] <= e0;
    end
    if (push1) begin
      mem[wr_ptr_r + PTR_W'(1)] <= e1;
    end
  end

  `RRC_ASSERT_SAME(a_queue_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(FIFO_DEPTH))
  `RRC_ASSERT_SAME(a_open_has_leaf, clk, rst_n, run_open_r, wp_r != '0)
  `RRC_ASSERT_NEXT(a_last_clears, clk, rst_n, in_acc && in_ch.data.last_leaf,
                   !run_open_r && (wp_r == '0))

endmodule
